/* sv/ftrm_pkg.sv */
`timescale 1ns / 1ps
// Package for the fan tachometer speed monitor.
// Shared constants, codes and controller/datapath interface structs. No dependencies.
package ftrm_pkg;

	localparam int unsigned CHANNELS_DEF = 8;
	localparam int unsigned MAX_CHANNELS = 8;
	localparam int unsigned CH_W = 3;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned RPM_W = 16;
	localparam int unsigned STALL_W = 24;
	localparam int unsigned PPR_W = 4;
	localparam int unsigned HOLD_W = 8;
	localparam int unsigned KINDS_W = 16;
	localparam int unsigned THR_W = 64;
	localparam int unsigned CFG_IDX_W = 3;

	// Denominator is period (below 2^24) times ppr (up to 15): 28 bits.
	localparam int unsigned DEN_W = 28;
	localparam int unsigned NUM_W = 26;
	localparam logic [NUM_W-1:0] RPM_NUMERATOR = 26'd60000000;
	localparam logic [RPM_W-1:0] RPM_MAX = 16'hffff;

	localparam logic [CFG_IDX_W-1:0] REG_STALL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PPR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KINDS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOW1 = 3'd5;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_PUMP = 2'd2;

	localparam logic MODE_EDGE = 1'b0;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // capture the input beat
		logic edge_wr;   // apply an edge to the channel tables
		logic ch_start;  // begin evaluating the current channel
		logic div_step;  // one quotient bit of the divider
		logic ch_done;   // store the current channel's speed and low check
		logic ch_next;   // advance the channel pointer
		logic finish;    // update hold counters and publish the result
	} ftrm_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_edge;
		logic last_ch;
		logic div_last;
	} ftrm_sts_t;

endpackage

/* sv/ftrm_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the fan tachometer speed monitor.
// Depends on ftrm_pkg for the command and status structs.
module ftrm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_beat,
	input  logic                out_free,
	input  ftrm_pkg::ftrm_sts_t sts,
	output logic                busy,
	output ftrm_pkg::ftrm_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_CH = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_STORE = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.load = in_beat;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.is_edge) begin
					cmd.edge_wr = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_CH;
				end
			end
			ST_CH: begin
				cmd.ch_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.ch_done = 1'b1;
				if (sts.last_ch) begin
					state_d = ST_FINISH;
				end else begin
					cmd.ch_next = 1'b1;
					state_d = ST_CH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

/* sv/ftrm_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the fan tachometer speed monitor: channel tables, shared
// restoring divider, low checks, hold counters and output register. Uses ftrm_pkg.
module ftrm_datapath #(
	parameter int unsigned CHANNELS = ftrm_pkg::CHANNELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ftrm_pkg::ftrm_cmd_t                    cmd,
	output ftrm_pkg::ftrm_sts_t                    sts,
	input  logic                                   cfg_we,
	input  logic [ftrm_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [ftrm_pkg::THR_W-1:0]             cfg_data,
	input  logic                                   in_mode,
	input  logic [ftrm_pkg::CH_W-1:0]              in_channel,
	input  logic [ftrm_pkg::TIME_W-1:0]            in_now,
	input  logic                                   in_standby,
	input  logic [ftrm_pkg::MAX_CHANNELS-1:0]      in_duty,
	input  logic                                   out_take,
	output logic                                   out_valid,
	output logic [ftrm_pkg::MAX_CHANNELS*ftrm_pkg::RPM_W-1:0] out_rpm,
	output logic                                   out_pump_alarm,
	output logic                                   out_fan_low
);

	localparam int unsigned NCH = ftrm_pkg::MAX_CHANNELS;
	localparam int unsigned RW = ftrm_pkg::RPM_W;
	localparam int unsigned DW = ftrm_pkg::DEN_W;
	localparam int unsigned NW = ftrm_pkg::NUM_W;
	localparam int unsigned BW = $clog2(NW + 1);

	// Configuration registers.
	logic [ftrm_pkg::STALL_W-1:0] stall_q;
	logic [ftrm_pkg::PPR_W-1:0]   ppr_q;
	logic [ftrm_pkg::HOLD_W-1:0]  hold_q;
	logic [ftrm_pkg::KINDS_W-1:0] kinds_q;
	logic [ftrm_pkg::THR_W-1:0]   low0_q;
	logic [ftrm_pkg::THR_W-1:0]   low1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_q <= 24'd1000000;
			ppr_q <= 4'd2;
			hold_q <= 8'd3;
			kinds_q <= '0;
			low0_q <= '0;
			low1_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				ftrm_pkg::REG_STALL: stall_q <= cfg_data[ftrm_pkg::STALL_W-1:0];
				ftrm_pkg::REG_PPR: ppr_q <= cfg_data[ftrm_pkg::PPR_W-1:0];
				ftrm_pkg::REG_HOLD: hold_q <= cfg_data[ftrm_pkg::HOLD_W-1:0];
				ftrm_pkg::REG_KINDS: kinds_q <= cfg_data[ftrm_pkg::KINDS_W-1:0];
				ftrm_pkg::REG_LOW0: low0_q <= cfg_data;
				ftrm_pkg::REG_LOW1: low1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured input beat.
	logic                          mode_q;
	logic [ftrm_pkg::CH_W-1:0]     chan_q;
	logic [ftrm_pkg::TIME_W-1:0]   now_q;
	logic                          standby_q;
	logic [NCH-1:0]                duty_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			chan_q <= in_channel;
			now_q <= in_now;
			standby_q <= in_standby;
			duty_q <= in_duty;
		end
	end

	// Channel tables.
	logic [ftrm_pkg::TIME_W-1:0] edge_time_q [NCH];
	logic [ftrm_pkg::TIME_W-1:0] period_q [NCH];
	logic [NCH-1:0]              seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < NCH; i++) begin
				edge_time_q[i] <= '0;
				period_q[i] <= '0;
			end
		end else if (cmd.edge_wr && (32'(chan_q) < CHANNELS)) begin
			if (seen_q[chan_q]) period_q[chan_q] <= now_q - edge_time_q[chan_q];
			edge_time_q[chan_q] <= now_q;
			seen_q[chan_q] <= 1'b1;
		end
	end

	// Per-channel evaluation with a shared restoring divider.
	logic [ftrm_pkg::CH_W-1:0] ch_q;
	logic                      zero_q;
	logic [DW-1:0]             den_q;
	logic [NW-1:0]             num_q;
	logic [DW:0]               rem_q;
	logic [NW-1:0]             quo_q;
	logic [BW-1:0]             bit_q;

	logic [ftrm_pkg::TIME_W-1:0] cur_period;
	logic [ftrm_pkg::TIME_W-1:0] cur_age;
	logic [ftrm_pkg::PPR_W-1:0]  ppr_eff;
	logic                        cur_zero;
	logic [DW:0]                 rem_sh;
	logic [DW:0]                 rem_sub;

	assign cur_period = period_q[ch_q];
	assign cur_age = now_q - edge_time_q[ch_q];
	assign ppr_eff = (ppr_q == '0) ? ftrm_pkg::PPR_W'(1) : ppr_q;
	assign cur_zero = !seen_q[ch_q] || (cur_period == '0)
		|| (cur_period > 32'(stall_q)) || (cur_age > 32'(stall_q))
		|| (32'(ch_q) >= CHANNELS);
	assign rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			bit_q <= '0;
		end else begin
			if (cmd.load) ch_q <= '0;
			else if (cmd.ch_next) ch_q <= ch_q + 1'b1;
			if (cmd.ch_start) bit_q <= '0;
			else if (cmd.div_step) bit_q <= bit_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ch_start) begin
			zero_q <= cur_zero;
			// Period is below 2^24 whenever the speed is nonzero.
			den_q <= DW'(cur_period[ftrm_pkg::STALL_W-1:0]) * DW'(ppr_eff);
			num_q <= ftrm_pkg::RPM_NUMERATOR;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (!rem_sub[DW]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// Speed and low check for the finished channel.
	logic [RW-1:0]  rpm_cur;
	logic [RW-1:0]  thr_cur;
	logic [1:0]     kind_cur;
	logic [RW-1:0]  rpm_q [NCH];
	logic           pump_hit_q;
	logic           fan_hit_q;
	logic           low_cur;

	assign rpm_cur = zero_q ? '0 :
		((quo_q > NW'(ftrm_pkg::RPM_MAX)) ? ftrm_pkg::RPM_MAX : quo_q[RW-1:0]);
	assign thr_cur = ch_q[ftrm_pkg::CH_W-1] ? low1_q[16*ch_q[1:0] +: RW]
		: low0_q[16*ch_q[1:0] +: RW];
	assign kind_cur = kinds_q[2*ch_q +: 2];
	assign low_cur = !standby_q && (kind_cur != ftrm_pkg::KIND_NONE) && duty_q[ch_q]
		&& (rpm_cur < thr_cur) && (32'(ch_q) < CHANNELS);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pump_hit_q <= 1'b0;
			fan_hit_q <= 1'b0;
		end else if (cmd.ch_done) begin
			rpm_q[ch_q] <= rpm_cur;
			if (low_cur && kind_cur == ftrm_pkg::KIND_PUMP) pump_hit_q <= 1'b1;
			if (low_cur && kind_cur != ftrm_pkg::KIND_PUMP) fan_hit_q <= 1'b1;
		end
	end

	// Hold counters and output register.
	logic [ftrm_pkg::HOLD_W-1:0] pump_run_q;
	logic [ftrm_pkg::HOLD_W-1:0] fan_run_q;
	logic [ftrm_pkg::HOLD_W-1:0] pump_run_d;
	logic [ftrm_pkg::HOLD_W-1:0] fan_run_d;

	assign pump_run_d = !pump_hit_q ? '0 : (pump_run_q < hold_q ? pump_run_q + 1'b1 : pump_run_q);
	assign fan_run_d = !fan_hit_q ? '0 : (fan_run_q < hold_q ? fan_run_q + 1'b1 : fan_run_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_run_q <= '0;
			fan_run_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.finish) begin
				pump_run_q <= pump_run_d;
				fan_run_q <= fan_run_d;
				out_valid <= 1'b1;
			end else if (out_take) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			for (int i = 0; i < NCH; i++) out_rpm[i*RW +: RW] <= rpm_q[i];
			out_pump_alarm <= (pump_run_d >= hold_q);
			out_fan_low <= (fan_run_d >= hold_q);
		end
	end

	assign sts.is_edge = (mode_q == ftrm_pkg::MODE_EDGE);
	assign sts.last_ch = (ch_q == ftrm_pkg::CH_W'(NCH - 1));
	assign sts.div_last = (bit_q == BW'(NW - 1));

endmodule

/* sv/fan_tach_rpm_monitor_core.sv */
`timescale 1ns / 1ps
// Top level of the fan tachometer speed monitor.
// Instantiates ftrm_ctrl and ftrm_datapath; uses ftrm_pkg.

// Edge beats (mode 0) record a tach edge time and period for one channel and
// produce no result. Update beats (mode 1) walk all eight channels through
// one shared 26-step restoring divider; each channel has one setup state, 26
// divide steps and one store state, and the result beat is published after
// the last channel once the output is free. The input is accepted only when the
// block is idle. The result register holds one beat, and the next update may
// enter while it waits; that update stalls at its end until the register frees.
module fan_tach_rpm_monitor_core #(
	parameter int unsigned CHANNELS = ftrm_pkg::CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [63:0]  cfg_data,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // mode[0], channel[3:1], now_us[35:4], standby[36],
	                                // duty_active[44:37], zero fill
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata    // rpm_ch0..rpm_ch7 16 bits each [127:0],
	                                // pump alarm[128], fan_low[129], zero fill
);

	ftrm_pkg::ftrm_cmd_t cmd;
	ftrm_pkg::ftrm_sts_t sts;
	logic busy;
	logic in_beat;
	logic out_beat;
	logic [127:0] rpm_bus;
	logic pump_alarm;
	logic fan_low;

	assign s_tready = !busy;
	assign in_beat = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	ftrm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_beat(in_beat),
		.out_free(!m_tvalid || m_tready), .sts(sts), .busy(busy), .cmd(cmd)
	);

	ftrm_datapath #(.CHANNELS(CHANNELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_mode(s_tdata[0]), .in_channel(s_tdata[3:1]), .in_now(s_tdata[35:4]),
		.in_standby(s_tdata[36]), .in_duty(s_tdata[44:37]),
		.out_take(out_beat), .out_valid(m_tvalid), .out_rpm(rpm_bus),
		.out_pump_alarm(pump_alarm), .out_fan_low(fan_low)
	);

	assign m_tdata = {6'd0, fan_low, pump_alarm, rpm_bus};

	// An accepted item makes the block busy; items are accepted only while idle.
	assert property (@(posedge clk) disable iff (!arst_n) in_beat |=> busy)
		else $error("accepted beat did not start work");
	// A result is published only when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result overwrote a pending beat");
	// A pending result holds until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped");

endmodule
